// ===== hw/rtl/mcgd_pkg.sv =====
// Shared types and constants of the mouse click gesture detector.
// No dependencies; every other file takes names from here by scope.
package mcgd_pkg;

   // coordinate width default and the width of the raw cursor fields
   localparam int CoordBitsDef = 12;
   localparam int RawBits      = 16;
   localparam int ExtBits      = RawBits + 1;
   localparam int TimeBits     = 32;
   localparam int WindowBits   = 16;

   // configuration port
   localparam int CsrIndexBits = 3;
   localparam int CsrDataBits  = 16;

   localparam logic [WindowBits-1:0] WindowReset = 16'd600;

   // register indexes
   localparam logic [CsrIndexBits-1:0] CsrAreaLeft   = 3'd0;
   localparam logic [CsrIndexBits-1:0] CsrAreaTop    = 3'd1;
   localparam logic [CsrIndexBits-1:0] CsrAreaRight  = 3'd2;
   localparam logic [CsrIndexBits-1:0] CsrAreaBottom = 3'd3;
   localparam logic [CsrIndexBits-1:0] CsrWindow     = 3'd4;

   // event flags of one result item
   typedef struct packed {
      logic left_pressed;
      logic right_pressed;
      logic left_touch;
      logic right_touch;
      logic left_click;
      logic right_click;
      logic left_double;
      logic right_double;
      logic drag_active;
      logic motion_seen;
   } flags_type;

endpackage

// ===== hw/rtl/mcgd_req_if.sv =====
// Input channel of the gesture detector: one frame sample per item.
// Depends on mcgd_pkg for field widths.
interface mcgd_req_if;
   logic                              valid;
   logic                              ready;
   logic [mcgd_pkg::TimeBits-1:0]     time_ms;
   logic signed [mcgd_pkg::RawBits-1:0] raw_x;
   logic signed [mcgd_pkg::RawBits-1:0] raw_y;
   logic                              left_down;
   logic                              right_down;
   logic                              moved;

   modport source (output valid, time_ms, raw_x, raw_y, left_down, right_down, moved,
                   input ready);
   modport sink   (input valid, time_ms, raw_x, raw_y, left_down, right_down, moved,
                   output ready);
endinterface

// ===== hw/rtl/mcgd_rsp_if.sv =====
// Result channel of the gesture detector: cursor and event flags per item.
// Depends on mcgd_pkg for the coordinate width default.
interface mcgd_rsp_if #(
   parameter int COORD_BITS = mcgd_pkg::CoordBitsDef
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] cursor_x;
   logic [COORD_BITS-1:0] cursor_y;
   logic                  left_pressed;
   logic                  right_pressed;
   logic                  left_touch;
   logic                  right_touch;
   logic                  left_click;
   logic                  right_click;
   logic                  left_double;
   logic                  right_double;
   logic                  drag_active;
   logic                  motion_seen;

   modport source (output valid, cursor_x, cursor_y, left_pressed, right_pressed,
                   left_touch, right_touch, left_click, right_click, left_double,
                   right_double, drag_active, motion_seen,
                   input ready);
   modport sink   (input valid, cursor_x, cursor_y, left_pressed, right_pressed,
                   left_touch, right_touch, left_click, right_click, left_double,
                   right_double, drag_active, motion_seen,
                   output ready);
endinterface

// ===== hw/rtl/mcgd_csr_if.sv =====
// Configuration write channel of the gesture detector.
// Depends on mcgd_pkg for index and data widths.
interface mcgd_csr_if;
   logic                                valid;
   logic                                ready;
   logic [mcgd_pkg::CsrIndexBits-1:0]   index;
   logic [mcgd_pkg::CsrDataBits-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/mcgd_clamp.sv =====
// Clamp of one signed raw coordinate into an unsigned [lo, hi] range.
// Depends on mcgd_pkg for the raw and extended widths.
module mcgd_clamp #(
   parameter int COORD_BITS = mcgd_pkg::CoordBitsDef
) (
   input  logic signed [mcgd_pkg::RawBits-1:0] raw,
   input  logic [COORD_BITS-1:0]               lo,
   input  logic [COORD_BITS-1:0]               hi,
   output logic [COORD_BITS-1:0]               value
);

   localparam int PadBits = mcgd_pkg::ExtBits - COORD_BITS;

   logic signed [mcgd_pkg::ExtBits-1:0] raw_ext;
   logic signed [mcgd_pkg::ExtBits-1:0] lo_ext;
   logic signed [mcgd_pkg::ExtBits-1:0] hi_ext;
   logic signed [mcgd_pkg::ExtBits-1:0] raised;
   logic signed [mcgd_pkg::ExtBits-1:0] lowered;

   // sign-extend the raw value, zero-extend the bounds
   assign raw_ext = {raw[mcgd_pkg::RawBits-1], raw};
   assign lo_ext  = signed'({{PadBits{1'b0}}, lo});
   assign hi_ext  = signed'({{PadBits{1'b0}}, hi});

   // raise to the low bound first, then lower to the high bound: high wins
   assign raised  = (raw_ext < lo_ext) ? lo_ext : raw_ext;
   assign lowered = (raised > hi_ext) ? hi_ext : raised;
   assign value   = lowered[COORD_BITS-1:0];

endmodule

// ===== hw/rtl/mouse_click_gesture_detector_unit.sv =====
// Top level of the mouse click gesture detector: input stage, event logic, result stage.
// Depends on mcgd_pkg, the three channel interfaces and mcgd_clamp.
//
//   channel  modport  direction  payload
//   req_if   sink     in         time_ms, raw_x, raw_y, left_down, right_down, moved
//   rsp_if   source   out        cursor_x/y, pressed, touch, click, double, drag, motion
//   csr_if   sink     in         index, data (always ready)
//
// One item per cycle while the result side keeps taking items; each item passes the
// input register and then sits in the result register until taken.
// The event logic between the two registers is a 32-bit subtract and compare per button.
// Reset is synchronous and clears all control state and configuration to defaults.
// A stalled result holds the input register; the input side stalls only when both are full.
module mouse_click_gesture_detector_unit #(
   parameter int COORD_BITS = mcgd_pkg::CoordBitsDef
) (
   input  logic       clock,
   input  logic       reset,
   mcgd_req_if.sink   req_if,
   mcgd_rsp_if.source rsp_if,
   mcgd_csr_if.sink   csr_if
);

   typedef logic [COORD_BITS-1:0] coord_type;

   // configuration
   coord_type                          area_left_ff, area_top_ff;
   coord_type                          area_right_ff, area_bottom_ff;
   logic [mcgd_pkg::WindowBits-1:0]    window_ff;

   // input stage
   logic                               s1_valid_ff;
   logic [mcgd_pkg::TimeBits-1:0]      s1_time_ff;
   logic signed [mcgd_pkg::RawBits-1:0] s1_x_ff, s1_y_ff;
   logic                               s1_left_ff, s1_right_ff, s1_moved_ff;

   // gesture state
   logic                               prev_left_ff, prev_right_ff;
   logic                               block_ff, armed_ff, dragging_ff;
   logic                               left_pend_ff, right_pend_ff;
   coord_type                          anchor_x_ff, anchor_y_ff;
   coord_type                          lfx_ff, lfy_ff, rfx_ff, rfy_ff;
   logic [mcgd_pkg::TimeBits-1:0]      lft_ff, rft_ff;

   // result stage
   logic                               out_valid_ff;
   coord_type                          out_x_ff, out_y_ff;
   mcgd_pkg::flags_type                out_flags_ff;

   // combinational values
   logic                               advance;
   coord_type                          cx, cy, x, y;
   coord_type                          anchor_x_a, anchor_y_a, anchor_x_in, anchor_y_in;
   logic                               blocked, left_eff, lt, rt, snap, armed_a;
   logic                               lp_a, rp_a, l_win, r_win, l_dbl, r_dbl;
   logic                               l_click, r_click;
   logic                               prev_left_in, prev_right_in, block_in;
   logic                               armed_in, dragging_in, left_pend_in, right_pend_in;
   logic                               lfirst_we, rfirst_we;
   logic [mcgd_pkg::TimeBits-1:0]      l_elapsed, r_elapsed, window_ext;
   mcgd_pkg::flags_type                flags_in;

   // handshakes
   assign advance      = s1_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || advance;
   assign csr_if.ready = 1'b1;

   // clamp both axes
   mcgd_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
      .raw(s1_x_ff), .lo(area_left_ff), .hi(area_right_ff), .value(cx)
   );
   mcgd_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
      .raw(s1_y_ff), .lo(area_top_ff), .hi(area_bottom_ff), .value(cy)
   );

   assign window_ext = {{(mcgd_pkg::TimeBits - mcgd_pkg::WindowBits){1'b0}}, window_ff};
   assign l_elapsed  = s1_time_ff - lft_ff;
   assign r_elapsed  = s1_time_ff - rft_ff;
   assign l_win      = l_elapsed < window_ext;
   assign r_win      = r_elapsed < window_ext;

   // event logic for the item in the input register
   always_comb begin
      blocked    = s1_left_ff && block_ff;
      left_eff   = s1_left_ff && !blocked;
      lt         = left_eff && !prev_left_ff;
      rt         = s1_right_ff && !prev_right_ff && !blocked;

      // left press edge captures the anchor and arms a drag
      anchor_x_a = lt ? cx : anchor_x_ff;
      anchor_y_a = lt ? cy : anchor_y_ff;
      armed_a    = left_eff && (lt || armed_ff);
      snap       = left_eff && !dragging_ff && armed_a && s1_moved_ff;
      x          = snap ? anchor_x_a : cx;
      y          = snap ? anchor_y_a : cy;

      // right press edge captures the anchor from the snapped cursor
      anchor_x_in = rt ? x : anchor_x_a;
      anchor_y_in = rt ? y : anchor_y_a;

      l_click = !blocked && prev_left_ff && !s1_left_ff &&
                anchor_x_in == x && anchor_y_in == y;
      r_click = !blocked && prev_right_ff && !s1_right_ff &&
                anchor_x_in == x && anchor_y_in == y;

      // drop a pending first press once the cursor leaves it
      lp_a  = left_pend_ff && lfx_ff == x && lfy_ff == y;
      rp_a  = right_pend_ff && rfx_ff == x && rfy_ff == y;
      l_dbl = lt && lp_a && l_win;
      r_dbl = rt && rp_a && r_win;
      lfirst_we = lt && !l_dbl;
      rfirst_we = rt && !r_dbl;

      if (blocked) begin
         prev_left_in  = 1'b0;
         prev_right_in = prev_right_ff;
         block_in      = block_ff;
         armed_in      = armed_ff;
         dragging_in   = dragging_ff;
         left_pend_in  = left_pend_ff;
         right_pend_in = right_pend_ff;
         anchor_x_in   = anchor_x_ff;
         anchor_y_in   = anchor_y_ff;
      end else begin
         prev_left_in  = s1_left_ff;
         prev_right_in = s1_right_ff;
         block_in      = l_dbl;
         armed_in      = armed_a && !snap;
         dragging_in   = left_eff && (dragging_ff || snap);
         left_pend_in  = lt ? !l_dbl : lp_a;
         right_pend_in = rt ? !r_dbl : rp_a;
      end

      flags_in.left_pressed  = left_eff;
      flags_in.right_pressed = s1_right_ff;
      flags_in.left_touch    = lt;
      flags_in.right_touch   = rt;
      flags_in.left_click    = l_click;
      flags_in.right_click   = r_click;
      flags_in.left_double   = l_dbl;
      flags_in.right_double  = r_dbl;
      flags_in.drag_active   = dragging_in;
      flags_in.motion_seen   = s1_moved_ff;
   end

   // configuration writes; mask to register width, ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         area_left_ff   <= '0;
         area_top_ff    <= '0;
         area_right_ff  <= '1;
         area_bottom_ff <= '1;
         window_ff      <= mcgd_pkg::WindowReset;
      end else if (csr_if.valid && csr_if.ready) begin
         unique case (csr_if.index)
            mcgd_pkg::CsrAreaLeft:   area_left_ff   <= csr_if.data[COORD_BITS-1:0];
            mcgd_pkg::CsrAreaTop:    area_top_ff    <= csr_if.data[COORD_BITS-1:0];
            mcgd_pkg::CsrAreaRight:  area_right_ff  <= csr_if.data[COORD_BITS-1:0];
            mcgd_pkg::CsrAreaBottom: area_bottom_ff <= csr_if.data[COORD_BITS-1:0];
            mcgd_pkg::CsrWindow:     window_ff      <= csr_if.data[mcgd_pkg::WindowBits-1:0];
            default: ;
         endcase
      end
   end

   // input register: take an item whenever the stage is free or moving on
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         s1_time_ff  <= req_if.time_ms;
         s1_x_ff     <= req_if.raw_x;
         s1_y_ff     <= req_if.raw_y;
         s1_left_ff  <= req_if.left_down;
         s1_right_ff <= req_if.right_down;
         s1_moved_ff <= req_if.moved;
      end
   end

   // advance gesture state as each item moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_left_ff  <= 1'b0;
         prev_right_ff <= 1'b0;
         block_ff      <= 1'b0;
         armed_ff      <= 1'b0;
         dragging_ff   <= 1'b0;
         left_pend_ff  <= 1'b0;
         right_pend_ff <= 1'b0;
         anchor_x_ff   <= '0;
         anchor_y_ff   <= '0;
         lfx_ff        <= '0;
         lfy_ff        <= '0;
         rfx_ff        <= '0;
         rfy_ff        <= '0;
         lft_ff        <= '0;
         rft_ff        <= '0;
      end else if (advance) begin
         prev_left_ff  <= prev_left_in;
         prev_right_ff <= prev_right_in;
         block_ff      <= block_in;
         armed_ff      <= armed_in;
         dragging_ff   <= dragging_in;
         left_pend_ff  <= left_pend_in;
         right_pend_ff <= right_pend_in;
         anchor_x_ff   <= anchor_x_in;
         anchor_y_ff   <= anchor_y_in;
         if (lfirst_we) begin
            lfx_ff <= x;
            lfy_ff <= y;
            lft_ff <= s1_time_ff;
         end
         if (rfirst_we) begin
            rfx_ff <= x;
            rfy_ff <= y;
            rft_ff <= s1_time_ff;
         end
      end
   end

   // result register: load on advance, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_x_ff     <= x;
         out_y_ff     <= y;
         out_flags_ff <= flags_in;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.cursor_x      = out_x_ff;
   assign rsp_if.cursor_y      = out_y_ff;
   assign rsp_if.left_pressed  = out_flags_ff.left_pressed;
   assign rsp_if.right_pressed = out_flags_ff.right_pressed;
   assign rsp_if.left_touch    = out_flags_ff.left_touch;
   assign rsp_if.right_touch   = out_flags_ff.right_touch;
   assign rsp_if.left_click    = out_flags_ff.left_click;
   assign rsp_if.right_click   = out_flags_ff.right_click;
   assign rsp_if.left_double   = out_flags_ff.left_double;
   assign rsp_if.right_double  = out_flags_ff.right_double;
   assign rsp_if.drag_active   = out_flags_ff.drag_active;
   assign rsp_if.motion_seen   = out_flags_ff.motion_seen;

   // a left double is always a press edge with the button reported down
   a_left_double_is_touch: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_flags_ff.left_double) |->
         (out_flags_ff.left_touch && out_flags_ff.left_pressed))
      else $error("left double without a reported press edge");

   // a right double is always a right press edge
   a_right_double_is_touch: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_flags_ff.right_double) |-> out_flags_ff.right_touch)
      else $error("right double without a right press edge");

   // a left double blocks the left button from the next item on
   a_double_sets_block: assert property (@(posedge clock) disable iff (reset)
      (advance && l_dbl) |=> block_ff)
      else $error("left double did not block the left button");

   // a blocked frame leaves the left button seen as released
   a_blocked_clears_prev: assert property (@(posedge clock) disable iff (reset)
      (advance && blocked) |=> (!prev_left_ff && block_ff))
      else $error("blocked frame did not clear the previous left level");

endmodule

// ===== tb/tb_mouse_click_gesture_detector_unit.sv =====
// Testbench for the mouse click gesture detector: directed frames, register settings,
// random gesture sequences and back-pressure, each result checked against a predictor.
// Depends on mcgd_pkg, the three channel interfaces and mouse_click_gesture_detector_unit.
`timescale 1ns / 100ps

module tb_mouse_click_gesture_detector_unit;

   localparam int CoordBits = mcgd_pkg::CoordBitsDef;
   localparam int unsigned RunLimitNs = 5_000_000;
   localparam int DrainLimit = 20000;
   localparam int SettleCycles = 8;
   localparam int PrintLimit = 40;
   localparam logic [mcgd_pkg::CsrIndexBits-1:0] CsrUnused = 3'd7;

   typedef struct {
      logic [mcgd_pkg::TimeBits-1:0]       time_ms;
      logic signed [mcgd_pkg::RawBits-1:0] raw_x;
      logic signed [mcgd_pkg::RawBits-1:0] raw_y;
      logic                                left_down;
      logic                                right_down;
      logic                                moved;
   } frame_sample_type;

   typedef struct {
      logic [CoordBits-1:0] cursor_x;
      logic [CoordBits-1:0] cursor_y;
      mcgd_pkg::flags_type  flags;
   } gesture_result_type;

   logic clock = 1'b0;
   logic reset;

   mcgd_req_if req_if ();
   mcgd_rsp_if rsp_if ();
   mcgd_csr_if csr_if ();

   mouse_click_gesture_detector_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the configuration
   logic [CoordBits-1:0]            win_left   = '0;
   logic [CoordBits-1:0]            win_top    = '0;
   logic [CoordBits-1:0]            win_right  = '1;
   logic [CoordBits-1:0]            win_bottom = '1;
   logic [mcgd_pkg::WindowBits-1:0] dbl_window = mcgd_pkg::WindowReset;

   // predictor copy of the gesture state
   bit                            held_left, held_right, left_locked, drag_ready, drag_on;
   logic [CoordBits-1:0]          press_x, press_y;
   logic [CoordBits-1:0]          left_tap_x, left_tap_y, right_tap_x, right_tap_y;
   logic [mcgd_pkg::TimeBits-1:0] left_tap_time, right_tap_time;
   bit                            left_tap_live, right_tap_live;

   gesture_result_type pending_gestures[$];

   // run bookkeeping
   int          mismatch_count;
   int          frames_sent;
   int          results_checked;
   int          clicks_seen, doubles_seen, drags_seen, locked_seen, settings_seen;
   logic [31:0] now_ms;
   bit          sender_idle_on;
   bit          sink_idle_on;
   int          hold_request;

   task automatic report_mismatch(input string what);
      if (mismatch_count < PrintLimit)
         $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic logic [CoordBits-1:0] clamp_to(
         input logic signed [mcgd_pkg::RawBits-1:0] raw,
         input logic [CoordBits-1:0] lo,
         input logic [CoordBits-1:0] hi);
      int v, lo_i, hi_i;
      v = int'(raw);
      lo_i = int'(lo);
      hi_i = int'(hi);
      // raise to the low bound first, so an inverted rectangle ends on the high bound
      if (v < lo_i)
         v = lo_i;
      if (v > hi_i)
         v = hi_i;
      return v[CoordBits-1:0];
   endfunction

   // advance the gesture state by one frame and return the result it produces
   function automatic gesture_result_type predict_gesture(input frame_sample_type s);
      gesture_result_type r;
      logic [CoordBits-1:0] x, y;
      logic [mcgd_pkg::TimeBits-1:0] elapsed;
      bit                   left, right;
      x = clamp_to(s.raw_x, win_left, win_right);
      y = clamp_to(s.raw_y, win_top, win_bottom);
      left = s.left_down;
      right = s.right_down;
      r.flags = '0;
      if (left && left_locked) begin
         // locked after a left double: drop the level, keep everything else
         held_left = 1'b0;
         left = 1'b0;
         locked_seen++;
      end else begin
         if (left) begin
            if (!held_left) begin
               press_x = x;
               press_y = y;
               r.flags.left_touch = 1'b1;
               drag_ready = 1'b1;
            end
            if (!drag_on && drag_ready && s.moved) begin
               x = press_x;
               y = press_y;
               drag_on = 1'b1;
               drag_ready = 1'b0;
               drags_seen++;
            end
         end else begin
            left_locked = 1'b0;
            drag_ready = 1'b0;
            drag_on = 1'b0;
         end
         if (!held_right && right) begin
            press_x = x;
            press_y = y;
            r.flags.right_touch = 1'b1;
         end
         r.flags.left_click = held_left && !left && press_x == x && press_y == y;
         r.flags.right_click = held_right && !right && press_x == x && press_y == y;
         // a cursor away from the first press forgets it
         if (left_tap_x != x || left_tap_y != y)
            left_tap_live = 1'b0;
         if (right_tap_x != x || right_tap_y != y)
            right_tap_live = 1'b0;
         if (left && !held_left) begin
            elapsed = s.time_ms - left_tap_time;
            if (left_tap_live && elapsed < {16'h0000, dbl_window}) begin
               r.flags.left_double = 1'b1;
               left_tap_live = 1'b0;
               left_locked = 1'b1;
            end else begin
               left_tap_x = x;
               left_tap_y = y;
               left_tap_time = s.time_ms;
               left_tap_live = 1'b1;
            end
         end
         if (right && !held_right) begin
            elapsed = s.time_ms - right_tap_time;
            if (right_tap_live && elapsed < {16'h0000, dbl_window}) begin
               r.flags.right_double = 1'b1;
               right_tap_live = 1'b0;
            end else begin
               right_tap_x = x;
               right_tap_y = y;
               right_tap_time = s.time_ms;
               right_tap_live = 1'b1;
            end
         end
         held_left = left;
         held_right = right;
      end
      r.cursor_x = x;
      r.cursor_y = y;
      r.flags.left_pressed = left;
      r.flags.right_pressed = right;
      r.flags.drag_active = drag_on;
      r.flags.motion_seen = s.moved;
      clicks_seen += int'(r.flags.left_click) + int'(r.flags.right_click);
      doubles_seen += int'(r.flags.left_double) + int'(r.flags.right_double);
      return r;
   endfunction

   // offer one frame, hold it until taken, then predict its result
   task automatic send_frame(input logic [31:0] t, input int x, input int y,
                             input bit l, input bit r, input bit m);
      frame_sample_type s;
      int gap;
      s.time_ms = t;
      s.raw_x = 16'(x);
      s.raw_y = 16'(y);
      s.left_down = l;
      s.right_down = r;
      s.moved = m;
      if (sender_idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 17);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.time_ms <= s.time_ms;
      req_if.raw_x <= s.raw_x;
      req_if.raw_y <= s.raw_y;
      req_if.left_down <= s.left_down;
      req_if.right_down <= s.right_down;
      req_if.moved <= s.moved;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pending_gestures.push_back(predict_gesture(s));
      frames_sent++;
   endtask

   // stop offering and wait until every expected result has been taken
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_gestures.size() != 0);
   endtask

   task automatic write_reg(input logic [mcgd_pkg::CsrIndexBits-1:0] idx,
                            input logic [mcgd_pkg::CsrDataBits-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      case (idx)
         mcgd_pkg::CsrAreaLeft:   win_left = value[CoordBits-1:0];
         mcgd_pkg::CsrAreaTop:    win_top = value[CoordBits-1:0];
         mcgd_pkg::CsrAreaRight:  win_right = value[CoordBits-1:0];
         mcgd_pkg::CsrAreaBottom: win_bottom = value[CoordBits-1:0];
         mcgd_pkg::CsrWindow:     dbl_window = value[mcgd_pkg::WindowBits-1:0];
         default: ;
      endcase
   endtask

   // program the whole rectangle and window, plus a write to an unused index
   task automatic configure(input logic [15:0] l, input logic [15:0] t, input logic [15:0] r,
                            input logic [15:0] b, input logic [15:0] w);
      write_reg(mcgd_pkg::CsrAreaLeft, l);
      write_reg(mcgd_pkg::CsrAreaTop, t);
      write_reg(mcgd_pkg::CsrAreaRight, r);
      write_reg(mcgd_pkg::CsrAreaBottom, b);
      write_reg(mcgd_pkg::CsrWindow, w);
      write_reg(CsrUnused, 16'($urandom));
      csr_if.valid <= 1'b0;
      settings_seen++;
   endtask

   task automatic advance_ms(input int lo, input int hi);
      now_ms = now_ms + $urandom_range(lo, hi);
   endtask

   function automatic int rand_coord();
      logic signed [15:0] r;
      case ($urandom_range(0, 9))
         0: r = 16'($urandom);
         1: r = 16'($urandom_range(0, 15));
         2: r = 16'($urandom_range(4080, 4095));
         default: r = 16'($urandom_range(0, 4095));
      endcase
      return int'(r);
   endfunction

   task automatic send_buttons(input int px, input int py, input bit use_right,
                               input bit down, input bit other, input bit mv);
      send_frame(now_ms, px, py, use_right ? other : down, use_right ? down : other, mv);
   endtask

   // one to three presses at one point, mostly within the double-click window
   task automatic play_taps(input bit use_right, input int px, input int py, input int taps);
      bit other;
      for (int k = 0; k < taps; k++) begin
         other = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 3) == 0)
            advance_ms(200, 70000);
         else
            advance_ms(1, 250);
         send_buttons(px, py, use_right, 1'b1, other, $urandom_range(0, 9) == 0);
         repeat ($urandom_range(0, 2)) begin
            advance_ms(1, 40);
            send_buttons(px, py, use_right, 1'b1, other, $urandom_range(0, 5) == 0);
         end
         advance_ms(1, 120);
         if ($urandom_range(0, 5) == 0)
            send_buttons(px + 1, py, use_right, 1'b0, other, 1'b1);
         else
            send_buttons(px, py, use_right, 1'b0, other, 1'b0);
      end
   endtask

   // press, move with the left button held, release near or at the press point
   task automatic play_drag(input int px, input int py);
      advance_ms(1, 3000);
      send_frame(now_ms, px, py, 1'b1, 1'b0, $urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 6)) begin
         advance_ms(1, 30);
         send_frame(now_ms, px + $urandom_range(0, 64) - 32, py + $urandom_range(0, 64) - 32,
                    1'b1, $urandom_range(0, 7) == 0, 1'b1);
      end
      advance_ms(1, 30);
      send_frame(now_ms, ($urandom_range(0, 2) == 0) ? px : px + 5, py, 1'b0, 1'b0,
                 1'($urandom_range(0, 1)));
   endtask

   task automatic play_noise(input int count);
      repeat (count) begin
         if ($urandom_range(0, 3) == 0)
            now_ms = $urandom;
         else
            advance_ms(0, 1000);
         send_frame(now_ms, rand_coord(), rand_coord(), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic play_gestures(input int count);
      int goal;
      int pick;
      goal = frames_sent + count;
      while (frames_sent < goal) begin
         pick = $urandom_range(0, 9);
         if (pick < 4)
            play_taps(1'b0, rand_coord(), rand_coord(), $urandom_range(1, 3));
         else if (pick < 6)
            play_taps(1'b1, rand_coord(), rand_coord(), $urandom_range(1, 3));
         else if (pick < 8)
            play_drag(rand_coord(), rand_coord());
         else
            play_noise($urandom_range(1, 4));
      end
   endtask

   // field extremes, click, locked double, drag snap, right double, wrapped and backward time
   task automatic test_directed_cases();
      send_frame(32'h0000_0000, -32768, -32768, 1'b0, 1'b0, 1'b0);
      send_frame(32'hFFFF_FFFF, 32767, 32767, 1'b0, 1'b0, 1'b1);
      send_frame(32'h0000_0001, 4096, -1, 1'b0, 1'b0, 1'b0);
      send_frame(1000, 100, 100, 1'b1, 1'b0, 1'b0);
      send_frame(1010, 100, 100, 1'b0, 1'b0, 1'b0);
      send_frame(1100, 100, 100, 1'b1, 1'b0, 1'b0);
      send_frame(1110, 100, 100, 1'b1, 1'b1, 1'b1);
      send_frame(1120, 100, 100, 1'b0, 1'b1, 1'b0);
      send_frame(1130, 100, 100, 1'b0, 1'b0, 1'b0);
      send_frame(2000, 200, 200, 1'b1, 1'b0, 1'b0);
      send_frame(2010, 260, 240, 1'b1, 1'b0, 1'b1);
      send_frame(2020, 300, 300, 1'b1, 1'b0, 1'b1);
      send_frame(2030, 300, 300, 1'b0, 1'b0, 1'b0);
      send_frame(3000, 300, 300, 1'b0, 1'b1, 1'b0);
      send_frame(3005, 300, 300, 1'b0, 1'b0, 1'b0);
      send_frame(3010, 300, 300, 1'b0, 1'b1, 1'b0);
      send_frame(3020, 300, 300, 1'b0, 1'b0, 1'b0);
      send_frame(32'hFFFF_FFF0, 10, 10, 1'b1, 1'b0, 1'b0);
      send_frame(32'hFFFF_FFF8, 10, 10, 1'b0, 1'b0, 1'b0);
      send_frame(32'h0000_0005, 10, 10, 1'b1, 1'b0, 1'b0);
      send_frame(5000, 10, 10, 1'b0, 1'b0, 1'b0);
      send_frame(5010, 10, 10, 1'b1, 1'b0, 1'b0);
      send_frame(5015, 10, 10, 1'b0, 1'b0, 1'b0);
      send_frame(4000, 10, 10, 1'b1, 1'b0, 1'b0);
      send_frame(4001, 11, 10, 1'b0, 1'b0, 1'b0);
      send_frame(4002, 10, 10, 1'b1, 1'b0, 1'b0);
   endtask

   // walk through rectangle and window settings, extremes and masking among them
   task automatic test_register_settings();
      wait_drained();
      configure(16'h0064, 16'h0032, 16'h0384, 16'h02BC, 16'd300);
      play_gestures(40);
      wait_drained();
      configure(16'hFBB8, 16'h0FFF, 16'h03E8, 16'h0000, 16'd0);
      play_gestures(40);
      wait_drained();
      configure(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      play_gestures(40);
      wait_drained();
      configure(16'h07D0, 16'h07D0, 16'h07D0, 16'h07D0, 16'd1);
      play_gestures(40);
      wait_drained();
      configure(16'h0000, 16'h0000, 16'h0FFF, 16'h0FFF, mcgd_pkg::WindowReset);
      play_gestures(40);
   endtask

   // random gestures in chunks, idling switched per chunk
   task automatic test_random_gestures();
      now_ms = $urandom;
      repeat (8) begin
         sender_idle_on = ($urandom_range(0, 3) != 0);
         sink_idle_on = ($urandom_range(0, 3) != 0);
         play_gestures(48);
      end
      sender_idle_on = 1'b1;
      sink_idle_on = 1'b1;
   endtask

   // receiver holds off while frames keep coming, then the sender waits for all results
   task automatic test_backpressure();
      sender_idle_on = 1'b0;
      hold_request = 80;
      play_gestures(24);
      wait_drained();
      sender_idle_on = 1'b1;
      play_gestures(16);
   endtask

   task automatic test_steady_stream();
      sender_idle_on = 1'b0;
      sink_idle_on = 1'b0;
      play_gestures(80);
   endtask

   // receiver: random stall bursts, long hold-offs on request
   initial begin : rsp_sink
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (sink_idle_on && $urandom_range(0, 5) == 0)
               stall_left = $urandom_range(1, 17);
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                   results_checked, name, got, want));
   endtask

   // compare each taken result with the oldest prediction
   always @(posedge clock) begin : rsp_check
      gesture_result_type want;
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_gestures.size() == 0) begin
            report_mismatch("result with no frame outstanding");
         end else begin
            want = pending_gestures.pop_front();
            check_field("cursor_x", 32'(rsp_if.cursor_x), 32'(want.cursor_x));
            check_field("cursor_y", 32'(rsp_if.cursor_y), 32'(want.cursor_y));
            check_field("left_pressed", 32'(rsp_if.left_pressed),
                        32'(want.flags.left_pressed));
            check_field("right_pressed", 32'(rsp_if.right_pressed),
                        32'(want.flags.right_pressed));
            check_field("left_touch", 32'(rsp_if.left_touch), 32'(want.flags.left_touch));
            check_field("right_touch", 32'(rsp_if.right_touch), 32'(want.flags.right_touch));
            check_field("left_click", 32'(rsp_if.left_click), 32'(want.flags.left_click));
            check_field("right_click", 32'(rsp_if.right_click), 32'(want.flags.right_click));
            check_field("left_double", 32'(rsp_if.left_double), 32'(want.flags.left_double));
            check_field("right_double", 32'(rsp_if.right_double),
                        32'(want.flags.right_double));
            check_field("drag_active", 32'(rsp_if.drag_active), 32'(want.flags.drag_active));
            check_field("motion_seen", 32'(rsp_if.motion_seen), 32'(want.flags.motion_seen));
         end
         results_checked++;
      end
   end

   initial begin : run_limit
      #(RunLimitNs);
      $display("run timed out with %0d results outstanding", pending_gestures.size());
      $display("tb_mouse_click_gesture_detector_unit failed");
      $finish;
   end

   initial begin : run_tests
      int drain_cycles;
      sender_idle_on = 1'b1;
      sink_idle_on = 1'b1;
      hold_request = 0;
      now_ms = '0;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.time_ms <= '0;
      req_if.raw_x <= '0;
      req_if.raw_y <= '0;
      req_if.left_down <= 1'b0;
      req_if.right_down <= 1'b0;
      req_if.moved <= 1'b0;
      csr_if.valid <= 1'b0;
      csr_if.index <= mcgd_pkg::CsrAreaLeft;
      csr_if.data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_register_settings();
      test_random_gestures();
      test_backpressure();
      test_steady_stream();

      // drain what is still in flight, then give stray results a chance to show
      req_if.valid <= 1'b0;
      drain_cycles = 0;
      while (pending_gestures.size() != 0 && drain_cycles < DrainLimit) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (SettleCycles) @(posedge clock);
      if (pending_gestures.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   pending_gestures.size()));

      $display("covered %0d frames and %0d results over %0d register settings",
               frames_sent, results_checked, settings_seen);
      $display("saw %0d clicks, %0d double clicks, %0d drag starts, %0d locked frames",
               clicks_seen, doubles_seen, drags_seen, locked_seen);
      if (mismatch_count == 0) begin
         $display("tb_mouse_click_gesture_detector_unit passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("tb_mouse_click_gesture_detector_unit failed");
      end
      $finish;
   end

endmodule
